// File: rtl/core/script_token_scanner_macros.svh
// ----------------------------------------------------------------------------
// Script token scanner assertion macros
// Shared forms for the concurrent checks of the scanner.
// ----------------------------------------------------------------------------
`ifndef SCRIPT_TOKEN_SCANNER_MACROS_SVH
`define SCRIPT_TOKEN_SCANNER_MACROS_SVH

// Condition a in a cycle requires condition b in the same cycle.
`define STS_ASSERT_IMPLY(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("scanner check failed");

// Condition a in a cycle requires condition b in the next cycle.
`define STS_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("scanner check failed");

`endif

// File: rtl/core/sts_pkg.sv
// ----------------------------------------------------------------------------
// Script token scanner package
// Token kinds, error codes, scan modes, character classes and keyword table.
// ----------------------------------------------------------------------------
package sts_pkg;

    localparam int KIND_W = 6;
    localparam int ERR_W  = 2;

    localparam logic [5:0] K_LPAREN = 6'd0;
    localparam logic [5:0] K_RPAREN = 6'd1;
    localparam logic [5:0] K_LBRACE = 6'd2;
    localparam logic [5:0] K_RBRACE = 6'd3;
    localparam logic [5:0] K_SEMI   = 6'd4;
    localparam logic [5:0] K_COMMA  = 6'd5;
    localparam logic [5:0] K_DOT    = 6'd6;
    localparam logic [5:0] K_PLUS   = 6'd8;
    localparam logic [5:0] K_MINUS  = 6'd9;
    localparam logic [5:0] K_STAR   = 6'd10;
    localparam logic [5:0] K_SLASH  = 6'd11;
    localparam logic [5:0] K_BANG   = 6'd12;
    localparam logic [5:0] K_ASSIGN = 6'd14;
    localparam logic [5:0] K_LESS   = 6'd16;
    localparam logic [5:0] K_GREATER = 6'd18;
    localparam logic [5:0] K_IDENT  = 6'd20;
    localparam logic [5:0] K_STRING = 6'd21;
    localparam logic [5:0] K_INT    = 6'd22;
    localparam logic [5:0] K_FLOAT  = 6'd23;
    localparam logic [5:0] K_KW0    = 6'd24;
    localparam logic [5:0] K_ERROR  = 6'd37;
    localparam logic [5:0] K_EOF    = 6'd38;

    localparam logic [1:0] E_NONE       = 2'd0;
    localparam logic [1:0] E_UNEXPECTED = 2'd1;
    localparam logic [1:0] E_UNTERM     = 2'd2;

    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_NL    = 8'h0a;
    localparam logic [7:0] CH_CR    = 8'h0d;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_DOT   = 8'h2e;
    localparam logic [7:0] CH_SLASH = 8'h2f;
    localparam logic [7:0] CH_EQ    = 8'h3d;
    localparam logic [7:0] CH_BANG  = 8'h21;
    localparam logic [7:0] CH_LT    = 8'h3c;
    localparam logic [7:0] CH_GT    = 8'h3e;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef enum logic [3:0] {
        M_IDLE, M_IDENT, M_INT, M_INT_DOT, M_FRAC, M_OP, M_SLASH, M_COMMENT, M_STRING
    } mode_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    localparam int NUM_KW = 13;

    localparam logic [47:0] KW_TEXT [NUM_KW] = '{
        "and   ", "do    ", "else  ", "false ", "fn    ", "if    ", "let   ",
        "null  ", "or    ", "return", "true  ", "then  ", "while "
    };

    localparam logic [2:0] KW_LEN [NUM_KW] = '{
        3'd3, 3'd2, 3'd4, 3'd5, 3'd2, 3'd2, 3'd3, 3'd4, 3'd2, 3'd6, 3'd4, 3'd4, 3'd5
    };

    function automatic logic is_alpha(logic [7:0] c);
        return (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a) || c == 8'h5f;
    endfunction

    function automatic logic is_digit(logic [7:0] c);
        return c >= 8'h30 && c <= 8'h39;
    endfunction

    function automatic logic [5:0] op_base(logic [7:0] p);
        logic [5:0] k;
        case (p)
            CH_DOT:  k = K_DOT;
            CH_BANG: k = K_BANG;
            CH_EQ:   k = K_ASSIGN;
            CH_LT:   k = K_LESS;
            default: k = K_GREATER;
        endcase
        return k;
    endfunction

    function automatic logic [5:0] ident_kind(logic [47:0] w, logic [2:0] n, logic short_word);
        logic [5:0] k;
        logic       hit;
        k = K_IDENT;
        for (int j = 0; j < NUM_KW; j++) begin
            hit = short_word && (n == KW_LEN[j]);
            for (int i = 0; i < 6; i++) begin
                if (3'(i) < n && w[8*i +: 8] != KW_TEXT[j][8*(5-i) +: 8]) begin
                    hit = 1'b0;
                end
            end
            if (hit) begin
                k = K_KW0 + 6'(j);
            end
        end
        return k;
    endfunction

endpackage

// File: rtl/core/sts_front.sv
// ----------------------------------------------------------------------------
// Scanner front end
// Classifies one byte per cycle while the queue has room and emits a record of up to three results.
// ----------------------------------------------------------------------------
module sts_front #(
    parameter int OFFSET_BITS    = 24,
    parameter int POS_BITS       = 16,
    parameter int KEYWORD_WINDOW = 7
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [7:0] in_char,
    input  sts_pkg::q_status_t q_status,
    output logic       in_ready,
    output logic       push,
    output logic [2+3*(8+OFFSET_BITS+3*POS_BITS)-1:0] rec
);
    import sts_pkg::*;

    localparam int RES_W = KIND_W + OFFSET_BITS + 3 * POS_BITS + ERR_W;
    localparam int IW    = $clog2(KEYWORD_WINDOW);

    mode_t                  mode_reg, mode_next;
    logic [OFFSET_BITS-1:0] ts_reg, ts_next;
    logic [OFFSET_BITS-1:0] off_reg, off_next;
    logic [POS_BITS-1:0]    len_reg, len_next;
    logic [POS_BITS-1:0]    line_reg, line_next;
    logic [POS_BITS-1:0]    col_reg, col_next;
    logic [POS_BITS-1:0]    scol_reg, scol_next;
    logic [7:0]             pend_reg, pend_next;
    logic [7:0]             win_reg [KEYWORD_WINDOW];

    logic             win_we;
    logic [IW-1:0]    win_idx;
    logic [7:0]       win_d;
    logic [RES_W-1:0] res [3];
    logic [1:0]       cnt;
    logic             do_idle, do_op, ext, accept;
    logic [5:0]       id_kind, pk;
    logic [47:0]      w;
    logic [7:0]       c;

    function automatic logic [POS_BITS-1:0] sat_pos(logic [POS_BITS-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic [OFFSET_BITS-1:0] sat_off(logic [OFFSET_BITS-1:0] v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic logic [RES_W-1:0] pack_res(logic [5:0] k, logic [OFFSET_BITS-1:0] o,
        logic [POS_BITS-1:0] l, logic [POS_BITS-1:0] ln, logic [POS_BITS-1:0] cl,
        logic [1:0] e);
        return {e, cl, ln, l, o, k};
    endfunction

    assign c        = in_char;
    assign in_ready = !q_status.full;
    assign accept   = in_valid && in_ready;
    assign push     = accept && (cnt != 2'd0);
    assign rec      = {cnt, res[2], res[1], res[0]};

    always_comb
    begin
        for (int i = 0; i < 6; i++) begin
            w[8*i +: 8] = win_reg[i];
        end
        id_kind = ident_kind(w, len_reg[2:0], len_reg <= POS_BITS'(6));
    end

    always_comb
    begin
        mode_next = mode_reg;
        ts_next   = ts_reg;
        off_next  = off_reg;
        len_next  = len_reg;
        line_next = line_reg;
        col_next  = col_reg;
        scol_next = scol_reg;
        pend_next = pend_reg;
        win_we    = 1'b0;
        win_idx   = '0;
        win_d     = c;
        cnt       = 2'd0;
        res[0]    = '0;
        res[1]    = '0;
        res[2]    = '0;
        do_idle   = 1'b0;
        do_op     = 1'b0;
        ext       = 1'b0;
        pk        = K_LPAREN;
        if (c == CH_NUL) begin
            case (mode_reg)
                M_IDENT:
                begin
                    res[cnt] = pack_res(id_kind, ts_reg, len_reg, line_reg, scol_reg, E_NONE);
                    cnt = cnt + 2'd1;
                end
                M_INT:
                begin
                    res[cnt] = pack_res(K_INT, ts_reg, len_reg, line_reg, scol_reg, E_NONE);
                    cnt = cnt + 2'd1;
                end
                M_INT_DOT:
                begin
                    res[cnt] = pack_res(K_INT, ts_reg, len_reg, line_reg, scol_reg, E_NONE);
                    cnt = cnt + 2'd1;
                    res[cnt] = pack_res(K_DOT, (off_reg != '0) ? off_reg - 1'b1 : '0,
                                        POS_BITS'(1), line_reg, col_reg, E_NONE);
                    cnt = cnt + 2'd1;
                end
                M_FRAC:
                begin
                    res[cnt] = pack_res(K_FLOAT, ts_reg, len_reg, line_reg, scol_reg, E_NONE);
                    cnt = cnt + 2'd1;
                end
                M_OP:
                begin
                    res[cnt] = pack_res(op_base(pend_reg), ts_reg, len_reg, line_reg,
                                        scol_reg, E_NONE);
                    cnt = cnt + 2'd1;
                end
                M_SLASH:
                begin
                    res[cnt] = pack_res(K_SLASH, ts_reg, len_reg, line_reg, scol_reg, E_NONE);
                    cnt = cnt + 2'd1;
                end
                M_STRING:
                begin
                    res[cnt] = pack_res(K_ERROR, ts_reg, len_reg, line_reg, sat_pos(col_reg),
                                        E_UNTERM);
                    cnt = cnt + 2'd1;
                end
                default:
                begin
                end
            endcase
            res[cnt] = pack_res(K_EOF, off_reg, '0, line_reg, sat_pos(col_reg), E_NONE);
            cnt = cnt + 2'd1;
            mode_next = M_IDLE;
            ts_next   = '0;
            off_next  = '0;
            len_next  = '0;
            line_next = POS_BITS'(1);
            col_next  = '0;
            scol_next = '0;
            pend_next = '0;
        end else begin
            case (mode_reg)
                M_IDENT:
                begin
                    if (is_alpha(c) || is_digit(c)) begin
                        ext = 1'b1;
                    end else begin
                        res[cnt] = pack_res(id_kind, ts_reg, len_reg, line_reg, scol_reg,
                                            E_NONE);
                        cnt = cnt + 2'd1;
                        do_idle = 1'b1;
                    end
                end
                M_INT:
                begin
                    if (is_digit(c)) begin
                        ext = 1'b1;
                    end else if (c == CH_DOT) begin
                        col_next  = sat_pos(col_next);
                        mode_next = M_INT_DOT;
                    end else begin
                        res[cnt] = pack_res(K_INT, ts_reg, len_reg, line_reg, scol_reg, E_NONE);
                        cnt = cnt + 2'd1;
                        do_idle = 1'b1;
                    end
                end
                M_INT_DOT:
                begin
                    if (is_digit(c)) begin
                        len_next  = sat_pos(len_next);
                        ext       = 1'b1;
                        mode_next = M_FRAC;
                    end else begin
                        res[cnt] = pack_res(K_INT, ts_reg, len_reg, line_reg, scol_reg, E_NONE);
                        cnt = cnt + 2'd1;
                        ts_next   = (off_reg != '0) ? off_reg - 1'b1 : '0;
                        scol_next = col_reg;
                        len_next  = POS_BITS'(1);
                        pend_next = CH_DOT;
                        do_op     = 1'b1;
                    end
                end
                M_FRAC:
                begin
                    if (is_digit(c)) begin
                        ext = 1'b1;
                    end else begin
                        res[cnt] = pack_res(K_FLOAT, ts_reg, len_reg, line_reg, scol_reg,
                                            E_NONE);
                        cnt = cnt + 2'd1;
                        do_idle = 1'b1;
                    end
                end
                M_OP:
                begin
                    do_op = 1'b1;
                end
                M_SLASH:
                begin
                    if (c == CH_SLASH) begin
                        col_next  = sat_pos(col_next);
                        mode_next = M_COMMENT;
                    end else begin
                        res[cnt] = pack_res(K_SLASH, ts_reg, len_reg, line_reg, scol_reg,
                                            E_NONE);
                        cnt = cnt + 2'd1;
                        do_idle = 1'b1;
                    end
                end
                M_COMMENT:
                begin
                    if (c != CH_NL) begin
                        col_next = sat_pos(col_next);
                    end else begin
                        do_idle = 1'b1;
                    end
                end
                M_STRING:
                begin
                    if (c == CH_QUOTE) begin
                        res[cnt] = pack_res(K_STRING, ts_reg, sat_pos(len_reg), line_reg,
                                            scol_reg, E_NONE);
                        cnt = cnt + 2'd1;
                        ext = 1'b1;
                        mode_next = M_IDLE;
                    end else if (c != CH_NL) begin
                        ext = 1'b1;
                    end else begin
                        res[cnt] = pack_res(K_ERROR, ts_reg, len_reg, line_reg,
                                            sat_pos(col_reg), E_UNTERM);
                        cnt = cnt + 2'd1;
                        do_idle = 1'b1;
                    end
                end
                default:
                begin
                    do_idle = 1'b1;
                end
            endcase

            if (do_op) begin
                if (c == ((pend_next == CH_DOT) ? CH_DOT : CH_EQ)) begin
                    res[cnt] = pack_res(op_base(pend_next) + 6'd1, ts_next, sat_pos(len_next),
                                        line_reg, scol_next, E_NONE);
                    cnt = cnt + 2'd1;
                    ext = 1'b1;
                    mode_next = M_IDLE;
                end else begin
                    res[cnt] = pack_res(op_base(pend_next), ts_next, len_next, line_reg,
                                        scol_next, E_NONE);
                    cnt = cnt + 2'd1;
                    do_idle = 1'b1;
                end
            end

            if (ext) begin
                col_next = sat_pos(col_next);
                if (len_next < POS_BITS'(KEYWORD_WINDOW)) begin
                    win_we  = 1'b1;
                    win_idx = len_next[IW-1:0];
                end
                len_next = sat_pos(len_next);
            end

            if (do_idle) begin
                mode_next = M_IDLE;
                if (c == CH_SPACE || c == CH_CR || c == CH_TAB) begin
                    col_next = sat_pos(col_next);
                end else if (c == CH_NL) begin
                    line_next = sat_pos(line_next);
                    col_next  = '0;
                end else begin
                    col_next = sat_pos(col_next);
                    case (c)
                        8'h28:   pk = K_LPAREN;
                        8'h29:   pk = K_RPAREN;
                        8'h7b:   pk = K_LBRACE;
                        8'h7d:   pk = K_RBRACE;
                        8'h3b:   pk = K_SEMI;
                        8'h2c:   pk = K_COMMA;
                        8'h2b:   pk = K_PLUS;
                        8'h2d:   pk = K_MINUS;
                        8'h2a:   pk = K_STAR;
                        default: pk = K_ERROR;
                    endcase
                    if (is_alpha(c) || is_digit(c) || c == CH_QUOTE || c == CH_SLASH ||
                        c == CH_DOT || c == CH_BANG || c == CH_EQ || c == CH_LT ||
                        c == CH_GT || pk != K_ERROR) begin
                        ts_next   = off_reg;
                        scol_next = col_next;
                        len_next  = POS_BITS'(1);
                        win_we    = 1'b1;
                        win_idx   = '0;
                        if (is_alpha(c)) begin
                            mode_next = M_IDENT;
                        end else if (is_digit(c)) begin
                            mode_next = M_INT;
                        end else if (c == CH_QUOTE) begin
                            mode_next = M_STRING;
                        end else if (c == CH_SLASH) begin
                            mode_next = M_SLASH;
                        end else if (pk == K_ERROR) begin
                            mode_next = M_OP;
                            pend_next = c;
                        end else begin
                            res[cnt] = pack_res(pk, off_reg, POS_BITS'(1), line_reg, col_next,
                                                E_NONE);
                            cnt = cnt + 2'd1;
                        end
                    end else begin
                        res[cnt] = pack_res(K_ERROR, off_reg, POS_BITS'(1), line_reg,
                                            col_next, E_UNEXPECTED);
                        cnt = cnt + 2'd1;
                    end
                end
            end
            off_next = sat_off(off_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg <= M_IDLE;
            ts_reg   <= '0;
            off_reg  <= '0;
            len_reg  <= '0;
            line_reg <= POS_BITS'(1);
            col_reg  <= '0;
            scol_reg <= '0;
            pend_reg <= '0;
        end else if (accept) begin
            mode_reg <= mode_next;
            ts_reg   <= ts_next;
            off_reg  <= off_next;
            len_reg  <= len_next;
            line_reg <= line_next;
            col_reg  <= col_next;
            scol_reg <= scol_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && win_we) begin
            win_reg[win_idx] <= win_d;
        end
    end

endmodule

// File: rtl/core/sts_fifo.sv
// ----------------------------------------------------------------------------
// Scanner record queue
// Short queue of result records between the front end and the back end.
// ----------------------------------------------------------------------------
module sts_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic [WIDTH-1:0] dout,
    output sts_pkg::q_status_t status
);
    import sts_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [AW-1:0]    wr_reg, wr_next;
    logic [AW-1:0]    rd_reg, rd_next;
    logic [AW:0]      cnt_reg, cnt_next;

    assign status.full  = (cnt_reg == (AW+1)'(DEPTH));
    assign status.empty = (cnt_reg == '0);
    assign dout         = mem[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push) begin
            wr_next = (wr_reg == AW'(DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop) begin
            rd_next = (rd_reg == AW'(DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + 1'b1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            mem[wr_reg] <= din;
        end
    end

endmodule

// File: rtl/core/sts_back.sv
// ----------------------------------------------------------------------------
// Scanner back end
// Unpacks each record into result beats, one per cycle while out_ready is high, marking the last.
// ----------------------------------------------------------------------------
module sts_back #(
    parameter int OFFSET_BITS = 24,
    parameter int POS_BITS    = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic [2+3*(8+OFFSET_BITS+3*POS_BITS)-1:0] rec,
    input  sts_pkg::q_status_t q_status,
    output logic pop,
    output logic out_valid,
    input  logic out_ready,
    output logic [8+OFFSET_BITS+3*POS_BITS-1:0] out_data,
    output logic out_last
);
    import sts_pkg::*;

    localparam int RES_W = KIND_W + OFFSET_BITS + 3 * POS_BITS + ERR_W;
    localparam int REC_W = 2 + 3 * RES_W;

    logic [REC_W-1:0] rec_reg;
    logic [1:0]       idx_reg;
    logic             busy_reg;
    logic             load, beat_done;
    logic [1:0]       rec_cnt;

    assign rec_cnt   = rec_reg[REC_W-1 -: 2];
    assign out_valid = busy_reg;
    assign out_data  = rec_reg[idx_reg * RES_W +: RES_W];
    assign out_last  = (idx_reg == rec_cnt - 2'd1);
    assign beat_done = busy_reg && out_ready;
    assign load      = !busy_reg || (beat_done && out_last);
    assign pop       = load && !q_status.empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end else if (load) begin
            busy_reg <= !q_status.empty;
            idx_reg  <= '0;
        end else if (beat_done) begin
            idx_reg <= idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop) begin
            rec_reg <= rec;
        end
    end

endmodule

// File: rtl/core/script_token_scanner.sv
// ----------------------------------------------------------------------------
// Script token scanner
// Cuts a byte stream into tokens with position information.
// ----------------------------------------------------------------------------
// Accepts one byte per cycle while the queue has room; result beats are held while m_tready is low.
// A byte's first result goes through the queue and the back-end record register before output.
// A byte causes up to three results; the four-record queue absorbs bursts.
// Reset clears the scan state and the queue at once; no clearing pass.
module script_token_scanner #(
    parameter int OFFSET_BITS    = 24,
    parameter int POS_BITS       = 16,
    parameter int KEYWORD_WINDOW = 7
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // char_code
    output logic       m_tvalid,
    input  logic       m_tready,
    // token_kind, start_offset, token_length, line_number, column_number, error_kind
    output logic [((8+OFFSET_BITS+3*POS_BITS+7)/8)*8-1:0] m_tdata,
    output logic       m_tlast
);
    import sts_pkg::*;

    localparam int RES_W  = KIND_W + OFFSET_BITS + 3 * POS_BITS + ERR_W;
    localparam int REC_W  = 2 + 3 * RES_W;
    localparam int DATA_W = ((RES_W + 7) / 8) * 8;

    q_status_t        q_status;
    logic             push, pop;
    logic [REC_W-1:0] rec_in, rec_out;
    logic [RES_W-1:0] res_data;

    sts_front #(
        .OFFSET_BITS   (OFFSET_BITS),
        .POS_BITS      (POS_BITS),
        .KEYWORD_WINDOW(KEYWORD_WINDOW)
    ) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_valid(s_tvalid),
        .in_char (s_tdata),
        .q_status(q_status),
        .in_ready(s_tready),
        .push    (push),
        .rec     (rec_in)
    );

    sts_fifo #(
        .WIDTH(REC_W),
        .DEPTH(4)
    ) u_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .din   (rec_in),
        .pop   (pop),
        .dout  (rec_out),
        .status(q_status)
    );

    sts_back #(
        .OFFSET_BITS(OFFSET_BITS),
        .POS_BITS   (POS_BITS)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .rec      (rec_out),
        .q_status (q_status),
        .pop      (pop),
        .out_valid(m_tvalid),
        .out_ready(m_tready),
        .out_data (res_data),
        .out_last (m_tlast)
    );

    assign m_tdata = DATA_W'(res_data);

endmodule

// File: rtl/core/sts_checker.sv
// ----------------------------------------------------------------------------
// Script token scanner checker
// Port-level checks on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "script_token_scanner_macros.svh"

module sts_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [7:0]  s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [79:0] m_tdata,
    input logic        m_tlast
);
    import sts_pkg::*;

    logic nul_beat;

    assign nul_beat = rst_n && s_tvalid && s_tready && (s_tdata == CH_NUL);

    `STS_ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    `STS_ASSERT_IMPLY(a_kind, clk, rst_n, m_tvalid, m_tdata[5:0] <= K_EOF)
    `STS_ASSERT_IMPLY(a_err, clk, rst_n, m_tvalid, (m_tdata[79:78] != E_NONE) == (m_tdata[5:0] == K_ERROR))
    `STS_ASSERT_IMPLY(a_eof, clk, rst_n, m_tvalid && m_tdata[5:0] == K_EOF, m_tlast && m_tdata[45:30] == 16'd0)
    `STS_ASSERT_NEXT(a_eof_out, clk, rst_n, $past(nul_beat), m_tvalid)

endmodule

bind script_token_scanner sts_checker u_sts_checker (.*);
